// ----- rtl/alc_pkg.sv -----
// Shared types and constants of the array list engine.
`default_nettype none

package alc_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int WORD_W      = 32;
    localparam int INDEX_W     = 6;
    localparam int OPCODE_W    = 3;
    localparam int COUNT_OUT_W = 7;
    localparam int STATUS_W    = 2;

    localparam int S_FIELDS_W = OPCODE_W + INDEX_W + WORD_W;
    localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
    localparam int M_FIELDS_W = 3 * WORD_W + COUNT_OUT_W + 1 + STATUS_W;
    localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

    typedef enum logic [OPCODE_W-1:0] {
        OP_PUSH   = 3'd0,
        OP_POP    = 3'd1,
        OP_GET    = 3'd2,
        OP_SET    = 3'd3,
        OP_INSERT = 3'd4,
        OP_REMOVE = 3'd5
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // What every cell of the row does on a command.
    typedef enum logic [1:0] {
        ACT_NONE   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_INSERT = 2'd2,
        ACT_REMOVE = 2'd3
    } act_t;

    typedef struct packed {
        act_t              act;
        logic [WORD_W-1:0] value;
    } cmd_t;

endpackage

`default_nettype wire

// ----- rtl/array_list_engine.sv -----
// Top level of the array list engine: command decode, cell row and result stages.
// A result passes through the stage one and stage two registers before it appears.
// Throughput: one operation per cycle while m_tready does not stall the output,
// insert and remove included, since the whole row of cells shifts in the cycle of the transfer.
// Reset clears the element count and both stage valid flags; the stored
// words are undefined until written and need no clearing pass.
`default_nettype none

module array_list_engine #(
    parameter int DEPTH = alc_pkg::DEPTH_DEFAULT
) (
    input  wire                           aclk,
    input  wire                           aresetn,
    input  wire                           s_tvalid,
    output logic                          s_tready,
    // From bit 0: opcode[2:0], index[8:3], value[40:9], zero fill.
    input  wire  [alc_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire                           m_tready,
    // From bit 0: read_value[31:0], front_value[63:32], back_value[95:64],
    // element_count[102:96], is_empty[103], status[105:104], zero fill.
    output logic [alc_pkg::M_TDATA_W-1:0] m_tdata
);
    import alc_pkg::*;

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

    // Input field split.
    opcode_t            in_op;
    logic [INDEX_W-1:0] in_index;
    logic [WORD_W-1:0]  in_value;

    assign in_op    = opcode_t'(s_tdata[OPCODE_W-1:0]);
    assign in_index = s_tdata[OPCODE_W +: INDEX_W];
    assign in_value = s_tdata[OPCODE_W + INDEX_W +: WORD_W];

    // Control state.
    logic [CW-1:0] count_reg, count_next;
    logic          pend_valid_reg, pend_valid_next;
    logic          out_valid_reg, out_valid_next;

    // Stage one carries the read word and status; stage two adds the list view.
    logic [WORD_W-1:0]      pend_rd_reg, pend_rd_next;
    status_t                pend_status_reg, pend_status_next;
    logic [WORD_W-1:0]      out_rd_reg, out_front_reg, out_back_reg;
    logic [COUNT_OUT_W-1:0] out_count_reg;
    logic                   out_empty_reg;
    status_t                out_status_reg;

    logic s_xfer, out_free, pend_move;

    assign out_free  = !out_valid_reg || m_tready;
    assign pend_move = pend_valid_reg && out_free;
    // A new command changes the cells, so it waits until the pending result
    // has picked up its list view.
    assign s_tready  = !pend_valid_reg || out_free;
    assign s_xfer    = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;

    // Command decode.
    logic          is_empty_now, is_full_now, idx_past;
    logic [IW-1:0] last_pos, clamp_pos;
    act_t          act;
    logic [IW-1:0] pos;
    status_t       status;
    logic [CW-1:0] count_after;
    logic          rd_hit;

    assign is_empty_now = (count_reg == '0);
    assign is_full_now  = (count_reg == CW'(DEPTH));
    assign idx_past     = (CMPW'(in_index) >= CMPW'(count_reg));
    assign last_pos     = IW'(count_reg - CW'(1));
    assign clamp_pos    = idx_past ? last_pos : IW'(in_index);

    always_comb begin
        act         = ACT_NONE;
        pos         = clamp_pos;
        status      = ST_DONE;
        count_after = count_reg;
        rd_hit      = 1'b0;
        unique case (in_op)
            OP_PUSH: begin
                pos = IW'(count_reg);
                if (is_full_now) begin
                    status = ST_FULL;
                end else begin
                    act         = ACT_WRITE;
                    count_after = count_reg + CW'(1);
                end
            end
            OP_POP: begin
                if (is_empty_now) status = ST_EMPTY;
                else              count_after = count_reg - CW'(1);
            end
            OP_GET: begin
                if (is_empty_now) status = ST_EMPTY;
                else              rd_hit = 1'b1;
            end
            OP_SET: begin
                if (is_empty_now) status = ST_EMPTY;
                else              act = ACT_WRITE;
            end
            OP_INSERT: begin
                // An index past the end appends.
                pos = idx_past ? IW'(count_reg) : IW'(in_index);
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else if (is_full_now) begin
                    status = ST_FULL;
                end else begin
                    act         = ACT_INSERT;
                    count_after = count_reg + CW'(1);
                end
            end
            OP_REMOVE: begin
                if (is_empty_now) begin
                    status = ST_EMPTY;
                end else begin
                    act         = ACT_REMOVE;
                    count_after = count_reg - CW'(1);
                end
            end
            default: begin
                act = ACT_NONE;
            end
        endcase
    end

    // Row of cells.
    cmd_t              cell_cmd;
    logic [IW-1:0]     back_pos;
    logic [WORD_W-1:0] word_w     [DEPTH];
    logic [WORD_W-1:0] rd_tap_w   [DEPTH];
    logic [WORD_W-1:0] back_tap_w [DEPTH];

    assign cell_cmd.act   = s_xfer ? act : ACT_NONE;
    assign cell_cmd.value = in_value;
    assign back_pos       = last_pos;

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic [WORD_W-1:0] left_w, right_w;
        if (i == 0) begin : g_first
            assign left_w = '0;
        end else begin : g_left
            assign left_w = word_w[i-1];
        end
        if (i == DEPTH - 1) begin : g_last
            assign right_w = '0;
        end else begin : g_right
            assign right_w = word_w[i+1];
        end
        alc_cell #(
            .IW  (IW),
            .IDX (i)
        ) u_cell (
            .aclk       (aclk),
            .cmd        (cell_cmd),
            .pos        (pos),
            .back_pos   (back_pos),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (word_w[i]),
            .rd_tap     (rd_tap_w[i]),
            .back_tap   (back_tap_w[i])
        );
    end

    // Only the selected cell drives a nonzero tap, so an OR collects it.
    logic [WORD_W-1:0] rd_or, back_or;

    always_comb begin
        rd_or   = '0;
        back_or = '0;
        for (int i = 0; i < DEPTH; i++) begin
            rd_or   = rd_or | rd_tap_w[i];
            back_or = back_or | back_tap_w[i];
        end
    end

    // Next values of the control state.
    always_comb begin
        count_next       = s_xfer ? count_after : count_reg;
        pend_rd_next     = rd_hit ? rd_or : '0;
        pend_status_next = status;

        if (s_xfer)         pend_valid_next = 1'b1;
        else if (out_free)  pend_valid_next = 1'b0;
        else                pend_valid_next = pend_valid_reg;

        if (pend_move)      out_valid_next = 1'b1;
        else if (m_tready)  out_valid_next = 1'b0;
        else                out_valid_next = out_valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            count_reg      <= count_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Stage one holds the item's own result while the cells take its update.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            pend_rd_reg     <= pend_rd_next;
            pend_status_reg <= pend_status_next;
        end
    end

    // Stage two reads front and back from the cells as the item left them.
    always_ff @(posedge aclk) begin
        if (pend_move) begin
            out_rd_reg     <= pend_rd_reg;
            out_status_reg <= pend_status_reg;
            out_count_reg  <= COUNT_OUT_W'(count_reg);
            out_empty_reg  <= is_empty_now;
            out_front_reg  <= is_empty_now ? '0 : word_w[0];
            out_back_reg   <= is_empty_now ? '0 : back_or;
        end
    end

    assign m_tdata = {
        (M_TDATA_W - M_FIELDS_W)'(0),
        out_status_reg,
        out_empty_reg,
        out_count_reg,
        out_back_reg,
        out_front_reg,
        out_rd_reg
    };

endmodule

`default_nettype wire

// ----- rtl/alc_cell.sv -----
// One storage cell of the list row with its shift and read-select logic.
`default_nettype none

module alc_cell #(
    parameter int IW  = 6,
    parameter int IDX = 0
) (
    input  wire                         aclk,
    input  wire alc_pkg::cmd_t          cmd,
    input  wire  [IW-1:0]               pos,
    input  wire  [IW-1:0]               back_pos,
    input  wire  [alc_pkg::WORD_W-1:0]  left_word,
    input  wire  [alc_pkg::WORD_W-1:0]  right_word,
    output logic [alc_pkg::WORD_W-1:0]  word,
    output logic [alc_pkg::WORD_W-1:0]  rd_tap,
    output logic [alc_pkg::WORD_W-1:0]  back_tap
);
    import alc_pkg::*;

    localparam logic [IW-1:0] MY_POS = IW'(IDX);

    logic [WORD_W-1:0] word_reg;
    logic [WORD_W-1:0] word_next;

    // Cells above the position move up on insert and down on remove; what
    // lands above the new count is never read.
    always_comb begin
        word_next = word_reg;
        unique case (cmd.act)
            ACT_NONE: begin
                word_next = word_reg;
            end
            ACT_WRITE: begin
                if (MY_POS == pos) word_next = cmd.value;
            end
            ACT_INSERT: begin
                if (MY_POS == pos)     word_next = cmd.value;
                else if (MY_POS > pos) word_next = left_word;
            end
            ACT_REMOVE: begin
                if (MY_POS >= pos) word_next = right_word;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        word_reg <= word_next;
    end

    assign word     = word_reg;
    assign rd_tap   = (MY_POS == pos)      ? word_reg : '0;
    assign back_tap = (MY_POS == back_pos) ? word_reg : '0;

endmodule

`default_nettype wire
